FILE: hdl/csi_pkg.sv
// Shared constants and request codes for the cubic stream interpolator.
package csi_pkg;

    localparam int CSI_SAMPLE_WIDTH = 24;
    localparam int CSI_PHASE_BITS   = 16;
    localparam int CSI_QUEUE_DEPTH  = 2;

    typedef enum logic [1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_TICK  = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

endpackage

FILE: hdl/csi_ifs.sv
// Valid/ready channel interfaces: input requests, results and step writes.
interface csi_in_if #(
    parameter int SAMPLE_WIDTH = 24
) ();
    logic                           valid;
    logic                           ready;
    logic [1:0]                     func;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, func, sample, input ready);
    modport sink   (input valid, func, sample, output ready);
endinterface

interface csi_out_if #(
    parameter int SAMPLE_WIDTH = 24
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] value;
    logic                           need_sample;

    modport source (output valid, value, need_sample, input ready);
    modport sink   (input valid, value, need_sample, output ready);
endinterface

interface csi_cfg_if #(
    parameter int PHASE_BITS = 16
) ();
    logic                  valid;
    logic                  ready;
    logic [PHASE_BITS:0]   step;

    modport source (output valid, step, input ready);
    modport sink   (input valid, step, output ready);
endinterface

FILE: hdl/csi_queue.sv
// Small register-based FIFO that carries tick jobs from front to back.
module csi_queue
    import csi_pkg::*;
#(
    parameter int DATA_WIDTH = 8,
    parameter int DEPTH      = CSI_QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_valid,
    output logic                  wr_ready,
    input  logic [DATA_WIDTH-1:0] wr_data,
    output logic                  rd_valid,
    input  logic                  rd_ready,
    output logic [DATA_WIDTH-1:0] rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] data_reg [DEPTH];
    logic [AW-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  do_wr, do_rd;

    assign wr_ready = (count_reg < CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = data_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            data_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: hdl/csi_front.sv
// Front end: takes requests, keeps window, phase and step, emits tick jobs.
module csi_front
    import csi_pkg::*;
#(
    parameter int SAMPLE_WIDTH = CSI_SAMPLE_WIDTH,
    parameter int PHASE_BITS   = CSI_PHASE_BITS,
    localparam int JOB_WIDTH   = 4 * SAMPLE_WIDTH + PHASE_BITS + 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    csi_in_if.sink               in,
    csi_cfg_if.sink              cfg,
    output logic                 job_valid,
    input  logic                 job_ready,
    output logic [JOB_WIDTH-1:0] job_data
);

    localparam logic [PHASE_BITS:0] STEP_ONE = (PHASE_BITS + 1)'(1) << PHASE_BITS;

    logic [SAMPLE_WIDTH-1:0] win_reg [4];
    logic [SAMPLE_WIDTH-1:0] win_next [4];
    logic [PHASE_BITS-1:0]   phase_reg, phase_next;
    logic                    empty_reg, empty_next;
    logic [PHASE_BITS:0]     step_reg, step_next;
    logic [PHASE_BITS:0]     phase_sum;
    logic                    accept;

    assign in.ready  = job_ready;
    assign cfg.ready = 1'b1;
    assign accept    = in.valid && in.ready;

    // Phase plus step stays below two whole samples; the top bit is the wrap.
    assign phase_sum = {1'b0, phase_reg} + step_reg;

    assign job_valid = accept && (in.func == FUNC_TICK);
    assign job_data  = {empty_reg, phase_sum[PHASE_BITS], phase_sum[PHASE_BITS-1:0],
                        win_reg[3], win_reg[2], win_reg[1], win_reg[0]};

    always_comb
    begin
        win_next   = win_reg;
        phase_next = phase_reg;
        empty_next = empty_reg;
        step_next  = step_reg;
        if (cfg.valid)
        begin
            step_next = (cfg.step > STEP_ONE) ? STEP_ONE : cfg.step;
        end
        if (accept)
        begin
            unique case (in.func)
                FUNC_PUSH:
                begin
                    if (empty_reg)
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            win_next[i] = in.sample;
                        end
                        empty_next = 1'b0;
                    end
                    else
                    begin
                        win_next[0] = win_reg[1];
                        win_next[1] = win_reg[2];
                        win_next[2] = win_reg[3];
                        win_next[3] = in.sample;
                    end
                end
                FUNC_TICK:
                begin
                    if (!empty_reg)
                    begin
                        phase_next = phase_sum[PHASE_BITS-1:0];
                    end
                end
                FUNC_CLEAR:
                begin
                    phase_next = '0;
                    empty_next = 1'b1;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                win_reg[i] <= '0;
            end
            phase_reg <= '0;
            empty_reg <= 1'b1;
            step_reg  <= STEP_ONE;
        end
        else
        begin
            win_reg   <= win_next;
            phase_reg <= phase_next;
            empty_reg <= empty_next;
            step_reg  <= step_next;
        end
    end

endmodule

FILE: hdl/csi_back.sv
// Back end: Horner evaluation on one shared multiplier, saturation, result register.
module csi_back
    import csi_pkg::*;
#(
    parameter int SAMPLE_WIDTH = CSI_SAMPLE_WIDTH,
    parameter int PHASE_BITS   = CSI_PHASE_BITS,
    localparam int JOB_WIDTH   = 4 * SAMPLE_WIDTH + PHASE_BITS + 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    output logic                 job_ready,
    input  logic [JOB_WIDTH-1:0] job_data,
    csi_out_if.source            out
);

    localparam int TW = SAMPLE_WIDTH + 5;
    localparam int PW = TW + PHASE_BITS + 1;
    localparam int SW = SAMPLE_WIDTH;

    localparam logic signed [PW-1:0] HALF = PW'(1) << (PHASE_BITS - 1);
    localparam logic signed [TW-1:0] SMAX = {{6{1'b0}}, {(SW - 1){1'b1}}};
    localparam logic signed [TW-1:0] SMIN = {{6{1'b1}}, {(SW - 1){1'b0}}};
    localparam logic [1:0]           ITER_LAST = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [1:0]              iter_reg, iter_next;
    logic signed [TW-1:0]    t_reg, t_next;
    logic signed [PW-1:0]    prod_reg, prod_next;
    logic signed [TW-1:0]    a1_reg, a1_next;
    logic signed [TW-1:0]    a2_reg, a2_next;
    logic signed [TW-1:0]    y1_reg, y1_next;
    logic [PHASE_BITS-1:0]   mu_reg, mu_next;
    logic                    need_reg, need_next;
    logic                    empty_reg, empty_next;
    logic                    out_valid_reg, out_valid_next;
    logic [SW-1:0]           out_value_reg, out_value_next;
    logic                    out_need_reg, out_need_next;

    logic signed [TW-1:0]    y0e, y1e, y2e, y3e;
    logic signed [TW-1:0]    a0c, a1c, a2c;
    logic signed [PHASE_BITS:0] mu_s;
    logic signed [PW-1:0]    prod_full;
    logic signed [PW-1:0]    prod_rnd;
    logic signed [TW-1:0]    addend;
    logic signed [TW-1:0]    t_add;
    logic [SW-1:0]           sat_value;

    // Unpack the job: window oldest first, then mu, wrap flag, empty flag.
    assign y0e = TW'($signed(job_data[SW-1:0]));
    assign y1e = TW'($signed(job_data[2*SW-1:SW]));
    assign y2e = TW'($signed(job_data[3*SW-1:2*SW]));
    assign y3e = TW'($signed(job_data[4*SW-1:3*SW]));

    assign a0c = y3e - y2e - y0e + y1e;
    assign a1c = y0e - y1e - a0c;
    assign a2c = y2e - y0e;

    assign mu_s      = $signed({1'b0, mu_reg});
    assign prod_full = PW'(t_reg) * PW'(mu_s);

    // Round half up, then floor by an arithmetic shift.
    assign prod_rnd = (prod_reg + HALF) >>> PHASE_BITS;
    assign t_add    = TW'(prod_rnd) + addend;

    always_comb
    begin
        case (iter_reg)
            2'd0:    addend = a1_reg;
            2'd1:    addend = a2_reg;
            default: addend = y1_reg;
        endcase
    end

    always_comb
    begin
        if (t_reg > SMAX)
        begin
            sat_value = SMAX[SW-1:0];
        end
        else if (t_reg < SMIN)
        begin
            sat_value = SMIN[SW-1:0];
        end
        else
        begin
            sat_value = t_reg[SW-1:0];
        end
    end

    assign job_ready       = (state_reg == ST_IDLE);
    assign out.valid       = out_valid_reg;
    assign out.value       = out_value_reg;
    assign out.need_sample = out_need_reg;

    always_comb
    begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        t_next         = t_reg;
        prod_next      = prod_reg;
        a1_next        = a1_reg;
        a2_next        = a2_reg;
        y1_next        = y1_reg;
        mu_next        = mu_reg;
        need_next      = need_reg;
        empty_next     = empty_reg;
        out_valid_next = out_valid_reg && !out.ready;
        out_value_next = out_value_reg;
        out_need_next  = out_need_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    t_next     = a0c;
                    a1_next    = a1c;
                    a2_next    = a2c;
                    y1_next    = y1e;
                    mu_next    = job_data[4*SW+PHASE_BITS-1:4*SW];
                    need_next  = job_data[4*SW+PHASE_BITS];
                    empty_next = job_data[4*SW+PHASE_BITS+1];
                    iter_next  = '0;
                    state_next = job_data[4*SW+PHASE_BITS+1] ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = prod_full;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                t_next = t_add;
                if (iter_reg == ITER_LAST)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    iter_next  = iter_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = empty_reg ? '0 : sat_value;
                    out_need_next  = need_reg || empty_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg         <= t_next;
        prod_reg      <= prod_next;
        a1_reg        <= a1_next;
        a2_reg        <= a2_next;
        y1_reg        <= y1_next;
        mu_reg        <= mu_next;
        need_reg      <= need_next;
        empty_reg     <= empty_next;
        out_value_reg <= out_value_next;
        out_need_reg  <= out_need_next;
    end

endmodule

FILE: hdl/cubic_stream_interpolator_unit.sv
// A tick job goes through the queue to the back end, which loads it, runs three
// multiply/add rounds, then loads the result register; an empty-window tick skips them.
// The back end takes a new tick job only when done with the last, as it has one shared
// multiplier; push and clear requests go at one per cycle while the job queue has room.
// Reset (rst_n, async, active low): window empty, phase zero, step one whole sample,
// queue and result register empty.
module cubic_stream_interpolator_unit
    import csi_pkg::*;
#(
    parameter int SAMPLE_WIDTH = CSI_SAMPLE_WIDTH,
    parameter int PHASE_BITS   = CSI_PHASE_BITS,
    parameter int QUEUE_DEPTH  = CSI_QUEUE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    csi_in_if.sink    in,
    csi_cfg_if.sink   cfg,
    csi_out_if.source out
);

    // A job holds the window snapshot, the new phase, the wrap flag and the empty flag.
    localparam int JOB_WIDTH = 4 * SAMPLE_WIDTH + PHASE_BITS + 2;

    logic                 fq_valid;
    logic                 fq_ready;
    logic [JOB_WIDTH-1:0] fq_data;
    logic                 qb_valid;
    logic                 qb_ready;
    logic [JOB_WIDTH-1:0] qb_data;

    // Front: apply push and clear at once, advance the phase on a tick unless the
    // window is empty, and hand every tick request to the queue with the window it sees.
    csi_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .PHASE_BITS   (PHASE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (in),
        .cfg       (cfg),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job_data  (fq_data)
    );

    // Queue: decouple the front from the multi-cycle evaluation.
    csi_queue #(
        .DATA_WIDTH (JOB_WIDTH),
        .DEPTH      (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    // Back: evaluate the cubic by Horner's rule, saturate, and hold the result
    // in its output register until the sink takes it.
    csi_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .PHASE_BITS   (PHASE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job_data  (qb_data),
        .out       (out)
    );

endmodule

FILE: test/csi_interp_checker.sv
`timescale 1ns / 100ps
// Checker that predicts interpolator results from accepted requests and compares them.
module csi_interp_checker
    import csi_pkg::*;
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic [1:0]                         in_func,
    input  logic signed [CSI_SAMPLE_WIDTH-1:0] in_sample,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [CSI_PHASE_BITS:0]            cfg_step,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic signed [CSI_SAMPLE_WIDTH-1:0] out_value,
    input  logic                               out_need_sample,
    output int                                 fail_count,
    output int                                 pending_count
);

    localparam int     SW           = CSI_SAMPLE_WIDTH;
    localparam int     PB           = CSI_PHASE_BITS;
    localparam longint UNIT         = longint'(1) << PB;
    localparam longint HALF         = UNIT / 2;
    localparam longint SAT_MAX      = (longint'(1) << (SW - 1)) - 1;
    localparam longint SAT_MIN      = -SAT_MAX - 1;
    localparam int     REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [SW-1:0] value;
        logic                 need_sample;
    } interp_result_t;

    logic signed [SW-1:0] win [4];
    logic [PB-1:0]        phase_acc;
    logic                 window_empty;
    logic [PB:0]          step_reg;
    interp_result_t       expected_results [$];
    interp_result_t       predicted;
    interp_result_t       oldest;
    longint               mu;
    int                   fails;

    // floor((x + half) / one): arithmetic shift rounds toward minus infinity
    function automatic longint round_half_up(longint x);
        return (x + HALF) >>> PB;
    endfunction

    // Horner evaluation of the four-point cubic on the current window
    function automatic logic signed [SW-1:0] horner_value(longint frac);
        longint y0, y1, y2, y3, a0, a1, a2, acc;
        y0 = win[0];
        y1 = win[1];
        y2 = win[2];
        y3 = win[3];
        a0 = y3 - y2 - y0 + y1;
        a1 = y0 - y1 - a0;
        a2 = y2 - y0;
        acc = a0;
        acc = round_half_up(acc * frac) + a1;
        acc = round_half_up(acc * frac) + a2;
        acc = round_half_up(acc * frac) + y1;
        if (acc > SAT_MAX)
            acc = SAT_MAX;
        if (acc < SAT_MIN)
            acc = SAT_MIN;
        return acc[SW-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                win[i] = '0;
            phase_acc    = '0;
            window_empty = 1'b1;
            step_reg     = (PB+1)'(UNIT);
            expected_results.delete();
            fails = 0;
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            // step writes saturate at one whole sample
            if (cfg_valid && cfg_ready)
                step_reg = (longint'(cfg_step) > UNIT) ? (PB+1)'(UNIT) : cfg_step;

            if (in_valid && in_ready)
            begin
                case (in_func)
                    FUNC_PUSH:
                    begin
                        if (window_empty)
                        begin
                            for (int i = 0; i < 4; i++)
                                win[i] = in_sample;
                            window_empty = 1'b0;
                        end
                        else
                        begin
                            for (int i = 0; i < 3; i++)
                                win[i] = win[i+1];
                            win[3] = in_sample;
                        end
                    end
                    FUNC_TICK:
                    begin
                        if (window_empty)
                        begin
                            predicted.value       = '0;
                            predicted.need_sample = 1'b1;
                        end
                        else
                        begin
                            mu = longint'(phase_acc) + longint'(step_reg);
                            predicted.need_sample = 1'b0;
                            if (mu >= UNIT)
                            begin
                                mu -= UNIT;
                                predicted.need_sample = 1'b1;
                            end
                            predicted.value = horner_value(mu);
                            phase_acc = mu[PB-1:0];
                        end
                        expected_results.push_back(predicted);
                    end
                    FUNC_CLEAR:
                    begin
                        phase_acc    = '0;
                        window_empty = 1'b1;
                    end
                    default: ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    fails++;
                    if (fails <= REPORT_LIMIT)
                        $display("unexpected result: value %0d need_sample %0b",
                                 out_value, out_need_sample);
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (oldest.value !== out_value || oldest.need_sample !== out_need_sample)
                    begin
                        fails++;
                        if (fails <= REPORT_LIMIT)
                            $display("mismatch: expected %0d/%0b, got %0d/%0b",
                                     oldest.value, oldest.need_sample,
                                     out_value, out_need_sample);
                    end
                end
            end

            fail_count    <= fails;
            pending_count <= expected_results.size();
        end
    end

endmodule

FILE: test/cubic_stream_interpolator_unit_test.sv
`timescale 1ns / 100ps
// Testbench top: drives requests and step writes into the interpolator and gives the verdict.
module cubic_stream_interpolator_unit_test;
    import csi_pkg::*;

    localparam int                   SW            = CSI_SAMPLE_WIDTH;
    localparam int                   PB            = CSI_PHASE_BITS;
    // func code the block must ignore
    localparam logic [1:0]           FUNC_UNUSED   = 2'd3;
    localparam logic [PB:0]          STEP_ONE      = (PB+1)'(1 << PB);
    localparam logic [PB:0]          STEP_HALF     = (PB+1)'(1 << (PB - 1));
    localparam logic [PB:0]          STEP_QUARTER  = (PB+1)'(1 << (PB - 2));
    localparam logic [PB:0]          STEP_ALL_ONES = '1;
    localparam logic signed [SW-1:0] SAMPLE_MAX    = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAMPLE_MIN    = {1'b1, {(SW-1){1'b0}}};
    localparam int                   IDLE_PCT      = 34;
    localparam int                   HOLD_CYCLES   = 300;
    // settle time after the last result, before touching the step
    localparam int                   SETTLE_CYCLES = 12;
    localparam int                   QUIET_LIMIT   = 3000;
    localparam int                   PHASE_ITEMS   = 155;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   gaps_on;
    bit   hold_req;
    int   fail_count;
    int   pending_count;

    csi_in_if  #(.SAMPLE_WIDTH(SW)) in_ch  ();
    csi_out_if #(.SAMPLE_WIDTH(SW)) out_ch ();
    csi_cfg_if #(.PHASE_BITS(PB))   cfg_ch ();

    cubic_stream_interpolator_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch),
        .cfg   (cfg_ch),
        .out   (out_ch)
    );

    csi_interp_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_ch.valid),
        .in_ready        (in_ch.ready),
        .in_func         (in_ch.func),
        .in_sample       (in_ch.sample),
        .cfg_valid       (cfg_ch.valid),
        .cfg_ready       (cfg_ch.ready),
        .cfg_step        (cfg_ch.step),
        .out_valid       (out_ch.valid),
        .out_ready       (out_ch.ready),
        .out_value       (out_ch.value),
        .out_need_sample (out_ch.need_sample),
        .fail_count      (fail_count),
        .pending_count   (pending_count)
    );

    always #2 clk = ~clk;

    // Offer one request and hold it until the block takes it. Valid stays high
    // after acceptance so that back-to-back requests need no second assignment
    // in the same step; the next call either drops it for a gap or replaces
    // the payload.
    task automatic offer_request(input logic [1:0] code, input logic signed [SW-1:0] data);
        if (gaps_on)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_ch.valid  <= 1'b1;
        in_ch.func   <= code;
        in_ch.sample <= data;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every predicted result has come back, then let
    // trailing push/clear requests settle inside the block.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the step register; only ever done with the block idle.
    task automatic write_step(input logic [PB:0] value);
        drain_results();
        cfg_ch.valid <= 1'b1;
        cfg_ch.step  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly full-range samples, with small values and both rails mixed in so
    // that the cubic overshoots and saturates now and then.
    function automatic logic signed [SW-1:0] random_sample();
        int pick;
        pick = $urandom_range(9);
        case (pick)
            6, 7:    return SW'($signed($urandom_range(2000)) - 1000);
            8:       return SAMPLE_MAX;
            9:       return SAMPLE_MIN;
            default: return SW'($urandom);
        endcase
    endfunction

    // Well-formed traffic is pushes and ticks; clears and the unused code are
    // kept rare so the window stays full most of the time.
    function automatic logic [1:0] random_code();
        int roll;
        roll = $urandom_range(99);
        if (roll < 45)
            return FUNC_PUSH;
        else if (roll < 92)
            return FUNC_TICK;
        else if (roll < 97)
            return FUNC_CLEAR;
        else
            return FUNC_UNUSED;
    endfunction

    // Send random requests; ignored requests do not count toward the total.
    task automatic run_random(input int count);
        int         sent;
        logic [1:0] code;
        sent = 0;
        while (sent < count)
        begin
            code = random_code();
            offer_request(code, random_sample());
            if (code != FUNC_UNUSED)
                sent++;
        end
    endtask

    // Result receiver: random back-pressure, plus one long hold-off on demand
    // so the job queue fills and the block stalls its input side.
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ch.ready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: end the run if no handshake of any kind happens for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        in_ch.valid  <= 1'b0;
        in_ch.func   <= FUNC_PUSH;
        in_ch.sample <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.step  <= STEP_ONE;
        gaps_on  = 1'b1;
        hold_req = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset step of one whole sample: every tick wraps.
        offer_request(FUNC_TICK, '0);           // tick on an empty window
        offer_request(FUNC_PUSH, SAMPLE_MAX);   // first push fills all four slots
        offer_request(FUNC_TICK, '0);
        offer_request(FUNC_PUSH, SAMPLE_MIN);
        offer_request(FUNC_PUSH, SAMPLE_MAX);
        offer_request(FUNC_PUSH, SAMPLE_MIN);
        offer_request(FUNC_TICK, '0);
        offer_request(FUNC_UNUSED, SAMPLE_MIN); // must leave no trace
        offer_request(FUNC_TICK, '0);
        offer_request(FUNC_CLEAR, '0);
        offer_request(FUNC_TICK, '0);           // empty again after a clear
        offer_request(FUNC_PUSH, SW'(-1));
        offer_request(FUNC_PUSH, SW'(1));
        offer_request(FUNC_TICK, '0);

        // Half-sample step: alternating rails give the largest overshoot.
        write_step(STEP_HALF);
        offer_request(FUNC_PUSH, SAMPLE_MIN);
        offer_request(FUNC_PUSH, SAMPLE_MAX);
        offer_request(FUNC_PUSH, SAMPLE_MIN);
        offer_request(FUNC_TICK, '0);
        offer_request(FUNC_TICK, '0);
        offer_request(FUNC_TICK, '0);

        // Step extremes: zero, all ones (saturates to one), one LSB, just below one.
        write_step('0);
        offer_request(FUNC_TICK, '0);
        write_step(STEP_ALL_ONES);
        offer_request(FUNC_TICK, '0);
        write_step((PB+1)'(1));
        offer_request(FUNC_TICK, '0);
        write_step(STEP_ONE - 1'b1);
        offer_request(FUNC_TICK, '0);
        offer_request(FUNC_TICK, '0);

        // Random requests at the step of one whole sample.
        write_step(STEP_ONE);
        run_random(PHASE_ITEMS);

        // Long stretch with no idling on either side.
        write_step((PB+1)'($urandom_range(1, (1 << PB) - 1)));
        gaps_on = 1'b0;
        run_random(PHASE_ITEMS);
        gaps_on = 1'b1;

        // Hold off the receiver while requests keep coming.
        write_step(STEP_QUARTER);
        hold_req = 1'b1;
        run_random(PHASE_ITEMS);

        // Steps above one whole sample saturate.
        write_step((PB+1)'($urandom_range((1 << PB) + 1, (1 << (PB + 1)) - 1)));
        run_random(PHASE_ITEMS);

        // Small steps, with a full pause in the middle.
        write_step((PB+1)'($urandom_range(1, 1024)));
        run_random(70);
        drain_results();
        run_random(PHASE_ITEMS - 70);

        write_step((PB+1)'($urandom_range(0, (1 << (PB + 1)) - 1)));
        run_random(PHASE_ITEMS);

        drain_results();
        if (fail_count == 0 && pending_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
